// ===== sv/tkhs_pkg.sv =====
// Shared types, codes and helpers for the top-k heap candidate selector.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package tkhs_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_HEAP_DEPTH = 64;
    localparam int DEF_ID_SPACE   = 4096;

    // Input opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_CAND   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_K      = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_OFFSET = 2'd3;

    localparam logic [6:0] K_RESET = 7'd10;

    // Datapath commands
    typedef logic [3:0] t_cmd;
    localparam t_cmd CMD_NONE     = 4'd0;
    localparam t_cmd CMD_CLR      = 4'd1;
    localparam t_cmd CMD_START    = 4'd2;
    localparam t_cmd CMD_ACCEPT   = 4'd3;
    localparam t_cmd CMD_MARK_RD  = 4'd4;
    localparam t_cmd CMD_MARK_WR  = 4'd5;
    localparam t_cmd CMD_PLACE    = 4'd6;
    localparam t_cmd CMD_UP_RD    = 4'd7;
    localparam t_cmd CMD_UP_MOVE  = 4'd8;
    localparam t_cmd CMD_ROOT_RD  = 4'd9;
    localparam t_cmd CMD_HOLE0    = 4'd10;
    localparam t_cmd CMD_DN_RDL   = 4'd11;
    localparam t_cmd CMD_DN_LATCH = 4'd12;
    localparam t_cmd CMD_DN_MOVE  = 4'd13;
    localparam t_cmd CMD_EMIT     = 4'd14;
    localparam t_cmd CMD_POP_LOAD = 4'd15;

    // Datapath status toward the controller
    typedef struct packed {
        logic id_ok;
        logic clr_last;
        logic keep;
        logic push;
        logic i_zero;
        logic e_gt_rd;
        logic s_lt_rd;
        logic l_lt_cnt;
        logic best_gt_e;
        logic cnt_zero;
        logic cnt_one;
        logic out_busy;
    } t_status;

    // Heap entry: score in the upper half, id in the lower half
    typedef logic [63:0] t_entry;

    // Order by signed score, then unsigned id
    function automatic logic ent_gt(input t_entry a, input t_entry b);
        return {~a[63], a[62:0]} > {~b[63], b[62:0]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/tkhs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the heap store and the visited marks.
`default_nettype none

module tkhs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, read port holds its data until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/tkhs_ctrl.sv =====
// Controller state machine of the top-k heap selector: sequences mark access,
// sift-up, sift-down, drain and the mark-clearing pass. Depends on tkhs_pkg.
`default_nettype none

module tkhs_ctrl
    import tkhs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_opcode,
    input  wire t_status    i_st,
    output logic            o_ready,
    output t_cmd            o_cmd
);

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MRD     = 4'd2;
    localparam logic [3:0] S_MWR     = 4'd3;
    localparam logic [3:0] S_UPRD    = 4'd4;
    localparam logic [3:0] S_UPCMP   = 4'd5;
    localparam logic [3:0] S_ROOT    = 4'd6;
    localparam logic [3:0] S_ROOTCMP = 4'd7;
    localparam logic [3:0] S_DNRDL   = 4'd8;
    localparam logic [3:0] S_DNRDR   = 4'd9;
    localparam logic [3:0] S_DNCMP   = 4'd10;
    localparam logic [3:0] S_DRD     = 4'd11;
    localparam logic [3:0] S_DEMIT   = 4'd12;
    localparam logic [3:0] S_DLOAD   = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_drain, n_drain;
    logic [3:0] after_sift;

    assign after_sift = r_drain ? S_DRD : S_IDLE;
    assign o_ready    = (r_state == S_IDLE);

    // Next state and command
    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_CLR: begin
                o_cmd = CMD_CLR;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    priority if (i_opcode == OP_START) begin
                        o_cmd   = CMD_START;
                        n_state = S_CLR;
                    end else if (i_opcode == OP_CAND) begin
                        o_cmd = CMD_ACCEPT;
                        if (i_st.id_ok) n_state = S_MRD;
                    end else if (i_opcode == OP_FINISH) begin
                        n_drain = 1'b1;
                        n_state = S_DRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MRD: begin
                o_cmd   = CMD_MARK_RD;
                n_state = S_MWR;
            end
            S_MWR: begin
                o_cmd = CMD_MARK_WR;
                priority if (!i_st.keep) n_state = S_IDLE;
                else if (i_st.push)      n_state = S_UPRD;
                else                     n_state = S_ROOT;
            end
            S_UPRD: begin
                if (i_st.i_zero) begin
                    o_cmd   = CMD_PLACE;
                    n_state = S_IDLE;
                end else begin
                    o_cmd   = CMD_UP_RD;
                    n_state = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (i_st.e_gt_rd) begin
                    o_cmd   = CMD_UP_MOVE;
                    n_state = S_UPRD;
                end else begin
                    o_cmd   = CMD_PLACE;
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                o_cmd   = CMD_ROOT_RD;
                n_state = S_ROOTCMP;
            end
            S_ROOTCMP: begin
                if (i_st.s_lt_rd) begin
                    o_cmd   = CMD_HOLE0;
                    n_state = S_DNRDL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DNRDL: begin
                if (i_st.l_lt_cnt) begin
                    o_cmd   = CMD_DN_RDL;
                    n_state = S_DNRDR;
                end else begin
                    o_cmd   = CMD_PLACE;
                    n_state = after_sift;
                end
            end
            S_DNRDR: begin
                o_cmd   = CMD_DN_LATCH;
                n_state = S_DNCMP;
            end
            S_DNCMP: begin
                if (i_st.best_gt_e) begin
                    o_cmd   = CMD_DN_MOVE;
                    n_state = S_DNRDL;
                end else begin
                    o_cmd   = CMD_PLACE;
                    n_state = after_sift;
                end
            end
            S_DRD: begin
                if (i_st.cnt_zero) begin
                    n_drain = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    o_cmd   = CMD_ROOT_RD;
                    n_state = S_DEMIT;
                end
            end
            S_DEMIT: begin
                // Hold the root until the output register is free
                if (!i_st.out_busy) begin
                    o_cmd   = CMD_EMIT;
                    n_state = i_st.cnt_one ? S_DRD : S_DLOAD;
                end
            end
            S_DLOAD: begin
                o_cmd   = CMD_POP_LOAD;
                n_state = S_DNRDL;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tkhs_dp.sv =====
// Datapath of the top-k heap selector: heap store, visited marks, sift
// registers and the output register. Depends on tkhs_pkg and tkhs_ram.
`default_nettype none

module tkhs_dp
    import tkhs_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
    parameter int ID_SPACE   = DEF_ID_SPACE
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [11:0] i_cand_id,
    input  wire logic [31:0] i_score,
    input  wire logic        i_mode,
    input  wire logic [6:0]  i_k,
    input  wire logic [31:0] i_radius,
    input  wire logic [31:0] i_offset,
    input  wire logic        i_out_ready,
    output t_status          o_st,
    output logic             o_out_valid,
    output logic [31:0]      o_out_id,
    output logic [31:0]      o_out_score,
    output logic             o_out_last,
    output logic             o_out_ovf
);

    localparam int HW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int XW = HW + 2;
    localparam int MW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;

    logic [11:0]   r_cid;
    logic [31:0]   r_score;
    logic [CW-1:0] r_cnt;
    logic [HW-1:0] r_i, r_ci;
    t_entry        r_e, r_c;
    logic          r_ovf;
    logic [MW-1:0] r_clr;
    logic          r_out_valid;
    logic [31:0]   r_out_id, r_out_score;
    logic          r_out_last, r_out_ovf;

    // Heap and mark memory ports
    logic          h_we, h_re;
    logic [HW-1:0] h_waddr, h_raddr;
    t_entry        h_wdata, h_rdata;
    logic          m_we, m_re, m_wdata;
    logic [MW-1:0] m_addr;
    logic [0:0]    m_rdata;

    tkhs_ram #(.WIDTH(64), .DEPTH(HEAP_DEPTH)) u_heap (
        .i_clk   (i_clk),
        .i_we    (h_we),
        .i_waddr (h_waddr),
        .i_wdata (h_wdata),
        .i_re    (h_re),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    tkhs_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_marks (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_addr),
        .i_wdata (m_wdata),
        .i_re    (m_re),
        .i_raddr (m_addr),
        .o_rdata (m_rdata)
    );

    // Candidate scoring and admission
    logic [31:0]   eff_score;
    t_entry        e_new;
    logic [6:0]    k_eff;
    logic [7:0]    limit;
    logic          in_radius, keep, push, full;

    assign eff_score = m_rdata[0] ? 32'd0 : r_score;
    assign e_new     = {eff_score, 32'(r_cid) + i_offset};
    assign in_radius = $signed(eff_score) < $signed(i_radius);
    assign full      = r_cnt >= CW'(HEAP_DEPTH);

    always_comb begin
        priority if (i_k == 7'd0)              k_eff = 7'd1;
        else if (i_k > 7'(HEAP_DEPTH))         k_eff = 7'(HEAP_DEPTH);
        else                                   k_eff = i_k;
    end

    assign limit = i_mode ? 8'(HEAP_DEPTH) : {1'b0, k_eff};
    assign keep  = !i_mode || in_radius;
    assign push  = keep && (8'(r_cnt) < limit);

    // Tree navigation
    logic [XW-1:0] l_x, r_x, cnt_x;
    logic          l_lt, r_lt, use_r;
    logic [HW-1:0] parent;
    t_entry        best;
    logic [HW-1:0] best_i;

    assign l_x    = XW'({r_i, 1'b1});
    assign r_x    = l_x + XW'(1);
    assign cnt_x  = XW'(r_cnt);
    assign l_lt   = l_x < cnt_x;
    assign r_lt   = r_x < cnt_x;
    assign parent = (r_i - HW'(1)) >> 1;
    assign use_r  = r_lt && ent_gt(h_rdata, r_c);
    assign best   = use_r ? h_rdata : r_c;
    assign best_i = use_r ? r_x[HW-1:0] : r_ci;

    // Status toward the controller
    assign o_st.id_ok     = 32'(i_cand_id) < 32'(ID_SPACE);
    assign o_st.clr_last  = r_clr == MW'(ID_SPACE - 1);
    assign o_st.keep      = keep;
    assign o_st.push      = push;
    assign o_st.i_zero    = r_i == '0;
    assign o_st.e_gt_rd   = ent_gt(r_e, h_rdata);
    assign o_st.s_lt_rd   = $signed(r_e[63:32]) < $signed(h_rdata[63:32]);
    assign o_st.l_lt_cnt  = l_lt;
    assign o_st.best_gt_e = ent_gt(best, r_e);
    assign o_st.cnt_zero  = r_cnt == '0;
    assign o_st.cnt_one   = r_cnt == CW'(1);
    assign o_st.out_busy  = r_out_valid;

    // Memory port steering
    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_i;
        h_wdata = r_e;
        h_re    = 1'b0;
        h_raddr = '0;
        m_we    = 1'b0;
        m_re    = 1'b0;
        m_wdata = 1'b0;
        m_addr  = MW'(r_cid);
        unique case (i_cmd)
            CMD_CLR: begin
                m_we   = 1'b1;
                m_addr = r_clr;
            end
            CMD_MARK_RD: m_re = 1'b1;
            CMD_MARK_WR: begin
                m_we    = 1'b1;
                m_wdata = 1'b1;
            end
            CMD_PLACE: h_we = 1'b1;
            CMD_UP_RD: begin
                h_re    = 1'b1;
                h_raddr = parent;
            end
            CMD_UP_MOVE: begin
                h_we    = 1'b1;
                h_wdata = h_rdata;
            end
            CMD_ROOT_RD: h_re = 1'b1;
            CMD_DN_RDL: begin
                h_re    = 1'b1;
                h_raddr = l_x[HW-1:0];
            end
            CMD_DN_LATCH: begin
                h_re    = r_lt;
                h_raddr = r_x[HW-1:0];
            end
            CMD_DN_MOVE: begin
                h_we    = 1'b1;
                h_wdata = best;
            end
            CMD_EMIT: begin
                h_re    = 1'b1;
                h_raddr = HW'(r_cnt - CW'(1));
            end
            default: begin
                h_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (i_cmd)
                CMD_START: begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                    r_clr <= '0;
                end
                CMD_CLR: r_clr <= r_clr + MW'(1);
                CMD_MARK_WR: begin
                    if (i_mode && in_radius && full) r_ovf <= 1'b1;
                    if (push) r_cnt <= r_cnt + CW'(1);
                end
                CMD_EMIT: begin
                    r_cnt       <= r_cnt - CW'(1);
                    r_out_valid <= 1'b1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_ACCEPT: begin
                r_cid   <= i_cand_id;
                r_score <= i_score;
            end
            CMD_MARK_WR: begin
                r_e <= e_new;
                if (push) r_i <= HW'(r_cnt);
            end
            CMD_UP_MOVE: r_i <= parent;
            CMD_HOLE0:   r_i <= '0;
            CMD_DN_LATCH: begin
                r_c  <= h_rdata;
                r_ci <= l_x[HW-1:0];
            end
            CMD_DN_MOVE: r_i <= best_i;
            CMD_EMIT: begin
                r_out_id    <= h_rdata[31:0];
                r_out_score <= h_rdata[63:32];
                r_out_last  <= r_cnt == CW'(1);
                r_out_ovf   <= r_ovf;
            end
            CMD_POP_LOAD: begin
                r_e <= h_rdata;
                r_i <= '0;
            end
            default: begin
                r_i <= r_i;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_id    = r_out_id;
    assign o_out_score = r_out_score;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

`default_nettype wire

// ===== sv/topk_heap_candidate_selector_top.sv =====
// Top level of the top-k heap candidate selector: register port, controller
// and datapath. Depends on tkhs_pkg, tkhs_ctrl and tkhs_dp.
`default_nettype none

// Keeps the best (lowest score) candidates of a query in a binary max-heap held
// in a single RAM and drains them worst-first on a finish transaction, one
// result per entry, tlast on the final one. One transaction is worked at a time.
// A candidate outside the radius is dropped after its mark access, and one that
// loses to the top after a compare with the root. A pushed candidate climbs by
// sift-up, and one that replaces the top descends by sift-down. Each drain step
// emits the top, waiting out any output stall, and while entries remain sifts
// the last entry down from the root. The heap RAM has a single read port. A
// start transaction, and reset, run a clearing pass over all ID_SPACE visited
// marks before the next transaction is accepted.
module topk_heap_candidate_selector_top
    import tkhs_pkg::*;
#(
    parameter int HEAP_DEPTH = DEF_HEAP_DEPTH,
    parameter int ID_SPACE   = DEF_ID_SPACE
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // opcode[1:0], cand_id[13:2], score[45:14]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // result_id[31:0], result_score[63:32]
    output logic             m_tlast,
    output logic [0:0]       m_tuser,   // overflow[0]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        r_mode;
    logic [6:0]  r_k;
    logic [31:0] r_radius, r_offset;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_k      <= K_RESET;
            r_radius <= '0;
            r_offset <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_MODE:   r_mode   <= pwdata[0];
                REG_K:      r_k      <= pwdata[6:0];
                REG_RADIUS: r_radius <= pwdata;
                REG_OFFSET: r_offset <= pwdata;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:   prdata = {31'd0, r_mode};
            REG_K:      prdata = {25'd0, r_k};
            REG_RADIUS: prdata = r_radius;
            REG_OFFSET: prdata = r_offset;
            default:    prdata = '0;
        endcase
    end

    t_cmd    cmd;
    t_status st;
    logic    out_ovf;

    tkhs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_opcode (s_tdata[1:0]),
        .i_st     (st),
        .o_ready  (s_tready),
        .o_cmd    (cmd)
    );

    tkhs_dp #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .ID_SPACE   (ID_SPACE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cand_id   (s_tdata[13:2]),
        .i_score     (s_tdata[45:14]),
        .i_mode      (r_mode),
        .i_k         (r_k),
        .i_radius    (r_radius),
        .i_offset    (r_offset),
        .i_out_ready (m_tready),
        .o_st        (st),
        .o_out_valid (m_tvalid),
        .o_out_id    (m_tdata[31:0]),
        .o_out_score (m_tdata[63:32]),
        .o_out_last  (m_tlast),
        .o_out_ovf   (out_ovf)
    );

    assign m_tuser = out_ovf;

endmodule

`default_nettype wire
